>>> rtl/twaxr_pkg.sv
// Shared types, constants and helper functions of the ten-word add-xor-rotate generator.
package twaxr_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 10;
  localparam int unsigned CntW     = $clog2(NumWords);

  localparam int unsigned RotSeed0 = 1;
  localparam int unsigned RotSeed1 = 21;
  localparam int unsigned RotSeed2 = 42;
  localparam int unsigned XsRight0 = 15;
  localparam int unsigned XsLeft   = 13;
  localparam int unsigned XsRight1 = 28;

  typedef logic [WordW-1:0] word_t;

  localparam word_t InitSeed = word_t'(64'h0000_0000_8765_4321);

  typedef enum logic [1:0] {
    OpInit = 2'd0,
    OpSeed = 2'd1,
    OpGen  = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic seed;
    logic mix;
    logic pick;
    logic fin;
  } ctl_t;

  function automatic word_t rol(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  function automatic word_t xorshift(input word_t v);
    word_t t;
    t = v;
    t = t ^ (t >> XsRight0);
    t = t ^ (t << XsLeft);
    t = t ^ (t >> XsRight1);
    return t;
  endfunction

endpackage

>>> rtl/twaxr_alu.sv
// Shared add-xor unit used for every mix step and for the final output combine.
module twaxr_alu (
  input  twaxr_pkg::word_t a_i,
  input  twaxr_pkg::word_t b_i,
  input  twaxr_pkg::word_t c_i,
  output twaxr_pkg::word_t r_o
);
  import twaxr_pkg::*;

  assign r_o = (a_i + b_i) ^ c_i;

endmodule

>>> rtl/twaxr_ctrl.sv
// Sequencer that drives the load, the mix steps on the shared unit, the pick and the output.
module twaxr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output twaxr_pkg::ctl_t    ctl_o
);
  import twaxr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StMix,
    StPick,
    StFin
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            gen_q, gen_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            last_step;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign last_step   = (cnt_q == CntW'(NumWords - 1));
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    gen_d       = gen_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (op_e'(operation_i))
            OpInit: begin
              ctl_o.load  = 1'b1;
              ctl_o.clear = 1'b1;
              ctl_o.seed  = 1'b1;
              gen_d       = 1'b0;
              state_d     = StMix;
            end
            OpSeed: begin
              ctl_o.load = 1'b1;
              ctl_o.seed = 1'b1;
              gen_d      = 1'b0;
              state_d    = StMix;
            end
            OpGen: begin
              ctl_o.load = 1'b1;
              gen_d      = 1'b1;
              state_d    = StMix;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
          cnt_d = '0;
        end
      end
      StMix: begin
        ctl_o.mix = 1'b1;
        cnt_d     = cnt_q + CntW'(1);
        if (last_step) begin
          state_d = gen_q ? StPick : StIdle;
        end
      end
      StPick: begin
        ctl_o.pick = 1'b1;
        state_d    = StFin;
      end
      StFin: begin
        if (!(out_valid_q && out_stall_i)) begin
          ctl_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      gen_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMix) |-> (cnt_q < CntW'(NumWords)))
    else $error("mix step count out of range");

  a_fin_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && !(out_valid_q && out_stall_i)) |=> out_valid_q)
    else $error("finished generate gave no word");

  a_word_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StFin))
    else $error("word raised outside the output step");

  a_seed_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMix && last_step && !gen_q) |=> (state_q == StIdle))
    else $error("seed or init did not return to idle after the mix");

endmodule

>>> rtl/ten_word_add_xor_rotate_prng_top.sv
// Top level of the ten-word add-xor-rotate generator: word store, seeding and selection.
//
// The block takes one operation word on the input channel (in_valid_i, in_stall_o) and
// answers generate operations with one word on the output channel (out_valid_o,
// out_stall_i). A word moves at a clock edge where valid is high and stall is low.
// Init clears the ten stored words and seeds words 0 to 2 with a fixed constant; seed adds
// seed_value_i into words 0 to 2; both run the mix and give no output word. Generate
// runs the mix and gives one random_value_o. Operation code 3 is ignored.
// The mix is ten dependent add-xor steps on one shared unit, one step a cycle.
// Init and seed keep in_stall_o high through the mix, so the next operation is taken
// only once the mix is done. Generate runs the mix, then a selection step and an output
// step; the input stays stalled until that output step. The output word sits in a
// register, so the next operation is accepted while it waits; if the receiver still
// stalls when the following generate is ready to finish, that generate waits in its
// output step and the input stalls.
// Reset clears all stored words to zero and leaves the block idle with no output word.
module ten_word_add_xor_rotate_prng_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [63:0]        seed_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        random_value_o
);
  import twaxr_pkg::*;

  // The store is kept rotated so that its first entry is always the word the next
  // mix step updates; ring entry i holds word (i + 3) mod 10 between operations.
  localparam int unsigned Slot0 = NumWords - 3;

  ctl_t  ctl;
  word_t ring_q [NumWords];
  word_t ring_d [NumWords];
  word_t wcan   [NumWords];
  word_t h1_q, h2_q, h3_q;
  word_t h1_d, h2_d, h3_d;
  word_t out_q;
  word_t seed_word;
  word_t s0, s1, s2;
  word_t alu_a, alu_b, alu_c, alu_r;
  logic [2:0]      base;
  logic [CntW-1:0] idx0, idx1, idx2;

  twaxr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  twaxr_alu u_alu (
    .a_i (alu_a),
    .b_i (alu_b),
    .c_i (alu_c),
    .r_o (alu_r)
  );

  for (genvar g = 0; g < NumWords; g++) begin : g_canon
    assign wcan[g] = ring_q[(g + Slot0) % NumWords];
  end

  assign seed_word = ctl.clear ? InitSeed : word_t'(seed_value_i);
  assign s0 = (ctl.clear ? word_t'(0) : ring_q[Slot0])
              + (ctl.seed ? rol(seed_word, RotSeed0) : word_t'(0));
  assign s1 = (ctl.clear ? word_t'(0) : ring_q[Slot0 + 1])
              + (ctl.seed ? rol(seed_word, RotSeed1) : word_t'(0));
  assign s2 = (ctl.clear ? word_t'(0) : ring_q[Slot0 + 2])
              + (ctl.seed ? rol(seed_word, RotSeed2) : word_t'(0));

  assign base = wcan[NumWords-1][2:0];
  assign idx0 = CntW'(base);
  assign idx1 = CntW'(base) + CntW'(1);
  assign idx2 = CntW'(base) + CntW'(2);

  assign alu_a = ctl.fin ? h3_q : ring_q[0];
  assign alu_b = ctl.fin ? h2_q : h3_q;
  assign alu_c = ctl.fin ? h1_q : rol(h1_q, RotSeed0);

  always_comb begin
    ring_d = ring_q;
    h1_d   = h1_q;
    h2_d   = h2_q;
    h3_d   = h3_q;
    if (ctl.load) begin
      if (ctl.clear) begin
        for (int i = 0; i < NumWords; i++) begin
          ring_d[i] = '0;
        end
      end
      ring_d[Slot0]     = s0;
      ring_d[Slot0 + 1] = s1;
      ring_d[Slot0 + 2] = s2;
      h3_d = s0;
      h2_d = s1;
      h1_d = s2;
    end else if (ctl.mix) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        ring_d[i] = ring_q[i + 1];
      end
      ring_d[NumWords-1] = alu_r;
      h3_d = h2_q;
      h2_d = h1_q;
      h1_d = alu_r;
    end else if (ctl.pick) begin
      h3_d = rol(wcan[idx0], RotSeed0);
      h2_d = rol(wcan[idx1], RotSeed1);
      h1_d = xorshift(wcan[idx2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      ring_q <= ring_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
    h2_q <= h2_d;
    h3_q <= h3_d;
    if (ctl.fin) begin
      out_q <= alu_r;
    end
  end

  assign random_value_o = out_q;

endmodule
